[hdl/mkd_pkg.sv]
// Morse key decoder package: shared types, register codes and the tree ROM.
// No dependencies; used by every other file of the block.

package mkd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned StepW   = 5;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [IdxW-1:0]    TreeTop      = 6'd31;
  localparam logic [StepW-1:0]   StepReset    = 5'd16;
  localparam logic [ThreshW-1:0] DashReset    = 16'd120;
  localparam logic [ThreshW-1:0] GapReset     = 16'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DASH_THRESHOLD = 2'd0,
    CFG_GAP_THRESHOLD  = 2'd1,
    CFG_ECHO_ENABLE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOT  = 2'd1,
    EV_DASH = 2'd2,
    EV_CHAR = 2'd3
  } event_e;

  typedef struct packed {
    logic [ThreshW-1:0] dash_threshold_ms;
    logic [ThreshW-1:0] gap_threshold_ms;
    logic               echo_enable;
  } cfg_t;

  typedef struct packed {
    logic             key_down;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    event_e           event_res;
    logic [CharW-1:0] character;
    logic             speaker_on;
  } result_t;

  // Dichotomic Morse tree, left = dot, right = dash, root at index 31.
  localparam logic [7:0] TREE_ROM [64] = '{
    "5", "H", "4", "S", "?", "V", "3", "I", "?", "F", "?", "U", "?", "?", "2", "E",
    "?", "L", "?", "R", "?", "?", "?", "A", "?", "P", "?", "W", "?", "J", "1", " ",
    "6", "B", "?", "D", "?", "X", "?", "N", "?", "C", "?", "K", "?", "Y", "?", "T",
    "7", "Z", "?", "G", "?", "Q", "?", "M", "8", "?", "?", "O", "9", "?", "0", "?"
  };

endpackage

[hdl/mkd_in_if.sv]
// Input channel of the Morse key decoder: valid/ready plus one key sample.
// Depends on mkd_pkg for field widths.

interface mkd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      key_down;
  logic [mkd_pkg::TimeW-1:0] now_ms;

  modport source (output valid, output key_down, output now_ms, input ready);
  modport sink   (input valid, input key_down, input now_ms, output ready);
endinterface

[hdl/mkd_out_if.sv]
// Result channel of the Morse key decoder: valid/ready plus one result.
// Depends on mkd_pkg for the event type and field widths.

interface mkd_out_if;
  logic                      valid;
  logic                      ready;
  mkd_pkg::event_e           event_res;
  logic [mkd_pkg::CharW-1:0] character;
  logic                      speaker_on;

  modport source (output valid, output event_res, output character, output speaker_on,
                  input ready);
  modport sink   (input valid, input event_res, input character, input speaker_on,
                  output ready);
endinterface

[hdl/mkd_core.sv]
// Decoder state and per-sample decode logic: press timing, tree walk, emit.
// Depends on mkd_pkg; state advances only when the top level strobes advance_i.

module mkd_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  mkd_pkg::item_t   item_i,
  input  mkd_pkg::cfg_t    cfg_i,
  output mkd_pkg::result_t result_o
);
  import mkd_pkg::*;

  logic               key_was_down_q, key_was_down_d;
  logic [TimeW-1:0]   press_start_q, press_start_d;
  logic [TimeW-1:0]   release_time_q, release_time_d;
  logic               waiting_q, waiting_d;
  logic [IdxW-1:0]    tree_index_q, tree_index_d;
  logic [StepW-1:0]   step_size_q, step_size_d;

  logic [TimeW-1:0]   press_dur;
  logic [TimeW-1:0]   gap_dur;
  logic               is_dash;
  logic               gap_done;
  logic [IdxW-1:0]    step_ext;

  assign press_dur = item_i.now_ms - press_start_q;
  assign gap_dur   = item_i.now_ms - release_time_q;
  assign is_dash   = press_dur > {{(TimeW-ThreshW){1'b0}}, cfg_i.dash_threshold_ms};
  assign gap_done  = gap_dur > {{(TimeW-ThreshW){1'b0}}, cfg_i.gap_threshold_ms};
  assign step_ext  = {{(IdxW-StepW){1'b0}}, step_size_q};

  always_comb begin
    key_was_down_d = item_i.key_down;
    press_start_d  = press_start_q;
    release_time_d = release_time_q;
    waiting_d      = waiting_q;
    tree_index_d   = tree_index_q;
    step_size_d    = step_size_q;

    result_o.event_res  = EV_NONE;
    result_o.character  = '0;
    result_o.speaker_on = item_i.key_down & cfg_i.echo_enable;

    if (item_i.key_down) begin
      if (!key_was_down_q) begin
        press_start_d = item_i.now_ms;
      end
    end else if (key_was_down_q) begin
      // Release: classify the press and walk one level down the tree.
      if (is_dash) begin
        tree_index_d       = tree_index_q + step_ext;
        result_o.event_res = EV_DASH;
      end else begin
        tree_index_d       = tree_index_q - step_ext;
        result_o.event_res = EV_DOT;
      end
      step_size_d    = step_size_q >> 1;
      release_time_d = item_i.now_ms;
      waiting_d      = 1'b1;
    end else if (waiting_q && gap_done) begin
      result_o.event_res = EV_CHAR;
      result_o.character = TREE_ROM[tree_index_q][CharW-1:0];
      tree_index_d       = TreeTop;
      step_size_d        = StepReset;
      waiting_d          = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_was_down_q <= 1'b0;
      press_start_q  <= '0;
      release_time_q <= '0;
      waiting_q      <= 1'b0;
      tree_index_q   <= TreeTop;
      step_size_q    <= StepReset;
    end else if (advance_i) begin
      key_was_down_q <= key_was_down_d;
      press_start_q  <= press_start_d;
      release_time_q <= release_time_d;
      waiting_q      <= waiting_d;
      tree_index_q   <= tree_index_d;
      step_size_q    <= step_size_d;
    end
  end

endmodule

[hdl/morse_key_decoder_unit.sv]
// Morse key decoder: one key sample in, one result out per transfer. Each sample
// is captured in an input register, decoded in a single pass against the decoder
// state (one 32-bit subtract and compare per timer, a 64-entry character ROM),
// and the result is held in an output register. A sample is taken every clock
// cycle as long as the result side keeps up. A stalled result register stops the
// decoder, and ready drops as soon as the input register holds a sample.
// Configuration writes apply on the clock edge after the write enable.

module morse_key_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mkd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mkd_pkg::CfgDatW-1:0] cfg_wdata_i,
  mkd_in_if.sink                      in_ch,
  mkd_out_if.source                   out_ch
);
  import mkd_pkg::*;

  cfg_t    cfg_q;
  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t core_res;
  logic    advance;
  logic    in_xfer;

  // Decode the held sample whenever the result register is free or draining.
  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dash_threshold_ms <= DashReset;
      cfg_q.gap_threshold_ms  <= GapReset;
      cfg_q.echo_enable       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DASH_THRESHOLD: cfg_q.dash_threshold_ms <= cfg_wdata_i[ThreshW-1:0];
        CFG_GAP_THRESHOLD:  cfg_q.gap_threshold_ms  <= cfg_wdata_i[ThreshW-1:0];
        CFG_ECHO_ENABLE:    cfg_q.echo_enable       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.key_down <= in_ch.key_down;
      in_item_q.now_ms   <= in_ch.now_ms;
    end
  end

  mkd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg_q),
    .result_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.event_res  = out_res_q.event_res;
  assign out_ch.character  = out_res_q.character;
  assign out_ch.speaker_on = out_res_q.speaker_on;

endmodule

[hdl/mkd_checker.sv]
// Port-level checks for the Morse key decoder, bound to the top level.
// Depends on mkd_pkg for the event codes.

module mkd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid,
  input logic                      out_ready,
  input mkd_pkg::event_e           out_event_res,
  input logic [mkd_pkg::CharW-1:0] out_character,
  input logic                      out_speaker_on
);
  import mkd_pkg::*;

  logic out_xfer;
  logic last_char_q;

  assign out_xfer = out_valid && out_ready;

  // Track whether the last transferred symbol-level result was a character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_char_q <= 1'b0;
    end else if (out_xfer && out_event_res == EV_CHAR) begin
      last_char_q <= 1'b1;
    end else if (out_xfer && (out_event_res == EV_DOT || out_event_res == EV_DASH)) begin
      last_char_q <= 1'b0;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_character) && $stable(out_speaker_on))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("result valid during reset");

  a_char_only_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_event_res != EV_CHAR |-> out_character == '0)
    else $error("character set without an emit");

  a_quiet_on_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_event_res != EV_NONE |-> !out_speaker_on)
    else $error("speaker on while key reported released");

  a_no_double_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_event_res == EV_CHAR |-> !last_char_q)
    else $error("two characters without a symbol between them");

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_event_res  (out_ch.event_res),
  .out_character  (out_ch.character),
  .out_speaker_on (out_ch.speaker_on)
);
